### hw/rtl/nearest_hand_touch_tagger_assert.svh
// assertion macros used by the top-level rtl file
`ifndef NEAREST_HAND_TOUCH_TAGGER_ASSERT_SVH
`define NEAREST_HAND_TOUCH_TAGGER_ASSERT_SVH

`ifndef SYNTHESIS
`define NHT_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("nht: same-cycle check failed");
`define NHT_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("nht: next-cycle check failed");
`else
`define NHT_ASSERT_IMP(name, ck, rn, ante, cons)
`define NHT_ASSERT_NXT(name, ck, rn, ante, cons)
`endif

`endif

### hw/rtl/nht_pkg.sv
`timescale 1ns / 1ps

package nht_pkg;

	localparam int HAND_SLOTS  = 8;
	localparam int TOUCH_SLOTS = 16;

	localparam int HAND_AW  = (HAND_SLOTS > 1) ? $clog2(HAND_SLOTS) : 1;
	localparam int TOUCH_AW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

	// one scan counter walks both tables
	localparam int SCAN_N  = (HAND_SLOTS > TOUCH_SLOTS) ? HAND_SLOTS : TOUCH_SLOTS;
	localparam int SCAN_IW = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

	localparam logic [SCAN_IW:0] HAND_LIM  = (SCAN_IW + 1)'(HAND_SLOTS);
	localparam logic [SCAN_IW:0] TOUCH_LIM = (SCAN_IW + 1)'(TOUCH_SLOTS);

	localparam int ID_W   = 16;
	localparam int POS_W  = 16;
	localparam int SQ_W   = 2 * POS_W;
	localparam int DIST_W = SQ_W + 1;

	typedef enum logic [1:0] {
		OP_HAND = 2'd0,
		OP_DOWN = 2'd1,
		OP_MOVE = 2'd2,
		OP_UP   = 2'd3
	} op_t;

	typedef struct packed {
		logic [ID_W-1:0]         key;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] x;
	} hand_ent_t;

	typedef struct packed {
		logic [ID_W-1:0] key;
		logic            found;
		logic [ID_W-1:0] hand;
	} touch_ent_t;

	typedef struct packed {
		logic                    clear;
		logic                    live;
		logic [ID_W-1:0]         key;
		logic signed [POS_W-1:0] hx;
		logic signed [POS_W-1:0] hy;
	} near_req_t;

	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] hand;
	} near_res_t;

endpackage

### hw/rtl/nht_ram.sv
`timescale 1ns / 1ps

module nht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/nht_nearest.sv
`timescale 1ns / 1ps

module nht_nearest (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nht_pkg::near_req_t               req,
	input  logic signed [nht_pkg::POS_W-1:0] px,
	input  logic signed [nht_pkg::POS_W-1:0] py,
	output nht_pkg::near_res_t               res
);

	logic signed [nht_pkg::POS_W:0]   dx;
	logic signed [nht_pkg::POS_W:0]   dy;
	logic [nht_pkg::POS_W:0]          ndx;
	logic [nht_pkg::POS_W:0]          ndy;
	logic [nht_pkg::POS_W-1:0]        ax;
	logic [nht_pkg::POS_W-1:0]        ay;
	logic [nht_pkg::SQ_W-1:0]         sqx_s2;
	logic [nht_pkg::SQ_W-1:0]         sqy_s2;
	logic [nht_pkg::ID_W-1:0]         key_s2;
	logic                             live_s2;
	logic [nht_pkg::DIST_W-1:0]       dsq;
	logic                             take;
	logic                             found_q;
	logic [nht_pkg::DIST_W-1:0]       best_q;
	logic [nht_pkg::ID_W-1:0]         hand_q;

	// magnitude of a 17-bit difference always fits 16 bits
	always_comb begin
		dx  = {px[nht_pkg::POS_W-1], px} - {req.hx[nht_pkg::POS_W-1], req.hx};
		dy  = {py[nht_pkg::POS_W-1], py} - {req.hy[nht_pkg::POS_W-1], req.hy};
		ndx = -dx;
		ndy = -dy;
		ax  = dx[nht_pkg::POS_W] ? ndx[nht_pkg::POS_W-1:0] : dx[nht_pkg::POS_W-1:0];
		ay  = dy[nht_pkg::POS_W] ? ndy[nht_pkg::POS_W-1:0] : dy[nht_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= nht_pkg::SQ_W'(ax) * nht_pkg::SQ_W'(ax);
		sqy_s2 <= nht_pkg::SQ_W'(ay) * nht_pkg::SQ_W'(ay);
		key_s2 <= req.key;
	end

	always_comb begin
		dsq = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		// ties go to the lower hand id
		take = live_s2 && (!found_q || (dsq < best_q) ||
			((dsq == best_q) && (key_s2 < hand_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s2 <= 1'b0;
			found_q <= 1'b0;
		end else if (req.clear) begin
			live_s2 <= 1'b0;
			found_q <= 1'b0;
		end else begin
			live_s2 <= req.live;
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= dsq;
			hand_q <= key_s2;
		end
	end

	assign res.found = found_q;
	assign res.hand  = found_q ? hand_q : '0;

endmodule

### hw/rtl/nearest_hand_touch_tagger.sv
`timescale 1ns / 1ps
`include "nearest_hand_touch_tagger_assert.svh"

// channel   dir  tdata (low bit up)                     tuser (low bit up)
// s_axis    in   item_id, pos_x, pos_y (48 bits)        opcode (2 bits)
// m_axis    out  touch_id, hand_id, out_x, out_y (64)   touch_kind, hand_found (3 bits)
//
// a beat is taken only in the idle state, so an item runs its table scan, drain and
// write-back before the next accept; the scan covers HAND_SLOTS entries for a hand update,
// TOUCH_SLOTS for move and up, and the larger of the two for a down
// the scan reads one entry of each table ram per cycle; the hand and touch rams are
// walked side by side, then the drain state covers the read and multiply latency, then
// come the write cycle and the idle state that takes the next beat
// arst_n clears the valid bits and control; table payload is never cleared
// a finished result waits in the output register while the next beat is taken; the
// write cycle holds only when that register is still full and not being drained

module nearest_hand_touch_tagger (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // item_id, pos_x, pos_y
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // touch_id, hand_id, out_x, out_y
	output logic [2:0]  m_axis_tuser   // touch_kind, hand_found
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                              state_q;
	logic                                drain_q;
	logic                                accept;
	logic                                can_load;
	logic                                done_go;

	nht_pkg::op_t                        op_q;
	logic [nht_pkg::ID_W-1:0]            id_q;
	logic signed [nht_pkg::POS_W-1:0]    x_q;
	logic signed [nht_pkg::POS_W-1:0]    y_q;

	logic [nht_pkg::SCAN_IW-1:0]         idx_q;
	logic [nht_pkg::SCAN_IW-1:0]         last_q;
	logic [nht_pkg::SCAN_IW-1:0]         idx_s1;
	logic                                issue_s1;

	logic [nht_pkg::HAND_SLOTS-1:0]      hand_valid_q;
	logic [nht_pkg::TOUCH_SLOTS-1:0]     touch_valid_q;

	nht_pkg::hand_ent_t                  hand_rd;
	nht_pkg::hand_ent_t                  hand_wd;
	nht_pkg::touch_ent_t                 touch_rd;
	nht_pkg::touch_ent_t                 touch_wd;
	logic                                hand_we;
	logic                                touch_we;
	logic [nht_pkg::HAND_AW-1:0]         hand_wa;
	logic [nht_pkg::TOUCH_AW-1:0]        touch_wa;

	logic [nht_pkg::HAND_AW-1:0]         hidx;
	logic [nht_pkg::TOUCH_AW-1:0]        tidx;
	logic                                hand_live;
	logic                                touch_live;

	logic                                hmatch_q;
	logic [nht_pkg::HAND_AW-1:0]         hslot_q;
	logic                                tmatch_q;
	logic [nht_pkg::TOUCH_AW-1:0]        tslot_q;
	logic                                tfound_q;
	logic [nht_pkg::ID_W-1:0]            thand_q;

	logic                                hfree_any;
	logic [nht_pkg::HAND_AW-1:0]         hfree;
	logic                                tfree_any;
	logic [nht_pkg::TOUCH_AW-1:0]        tfree;

	nht_pkg::near_req_t                  near_req;
	nht_pkg::near_res_t                  near_res;

	logic                                res_found;
	logic [nht_pkg::ID_W-1:0]            res_hand;

	logic                                out_valid_q;
	logic [nht_pkg::ID_W-1:0]            out_id_q;
	logic [1:0]                          out_kind_q;
	logic                                out_found_q;
	logic [nht_pkg::ID_W-1:0]            out_hand_q;
	logic [nht_pkg::POS_W-1:0]           out_x_q;
	logic [nht_pkg::POS_W-1:0]           out_y_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign can_load      = !out_valid_q || m_axis_tready;
	assign done_go       = (state_q == ST_DONE) && ((op_q == nht_pkg::OP_HAND) || can_load);

	// tables

	nht_ram #(
		.WIDTH ($bits(nht_pkg::hand_ent_t)),
		.DEPTH (nht_pkg::HAND_SLOTS)
	) u_hand_ram (
		.clk   (clk),
		.we    (hand_we),
		.waddr (hand_wa),
		.wdata (hand_wd),
		.raddr (idx_q[nht_pkg::HAND_AW-1:0]),
		.rdata (hand_rd)
	);

	nht_ram #(
		.WIDTH ($bits(nht_pkg::touch_ent_t)),
		.DEPTH (nht_pkg::TOUCH_SLOTS)
	) u_touch_ram (
		.clk   (clk),
		.we    (touch_we),
		.waddr (touch_wa),
		.wdata (touch_wd),
		.raddr (idx_q[nht_pkg::TOUCH_AW-1:0]),
		.rdata (touch_rd)
	);

	// read data stage

	always_comb begin
		hidx       = idx_s1[nht_pkg::HAND_AW-1:0];
		tidx       = idx_s1[nht_pkg::TOUCH_AW-1:0];
		hand_live  = issue_s1 && ({1'b0, idx_s1} < nht_pkg::HAND_LIM) && hand_valid_q[hidx];
		touch_live = issue_s1 && ({1'b0, idx_s1} < nht_pkg::TOUCH_LIM) &&
			touch_valid_q[tidx] && (touch_rd.key == id_q);
	end

	always_comb begin
		near_req.clear = accept;
		near_req.live  = hand_live && (op_q == nht_pkg::OP_DOWN);
		near_req.key   = hand_rd.key;
		near_req.hx    = hand_rd.x;
		near_req.hy    = hand_rd.y;
	end

	nht_nearest u_nearest (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (near_req),
		.px     (x_q),
		.py     (y_q),
		.res    (near_res)
	);

	// lowest free slot of each table
	always_comb begin
		hfree_any = 1'b0;
		hfree     = '0;
		for (int i = nht_pkg::HAND_SLOTS - 1; i >= 0; i--) begin
			if (!hand_valid_q[i]) begin
				hfree_any = 1'b1;
				hfree     = nht_pkg::HAND_AW'(i);
			end
		end
	end

	always_comb begin
		tfree_any = 1'b0;
		tfree     = '0;
		for (int i = nht_pkg::TOUCH_SLOTS - 1; i >= 0; i--) begin
			if (!touch_valid_q[i]) begin
				tfree_any = 1'b1;
				tfree     = nht_pkg::TOUCH_AW'(i);
			end
		end
	end

	// write-back
	always_comb begin
		hand_we      = 1'b0;
		hand_wa      = hmatch_q ? hslot_q : hfree;
		hand_wd.key  = id_q;
		hand_wd.x    = x_q;
		hand_wd.y    = y_q;
		touch_we       = 1'b0;
		touch_wa       = tmatch_q ? tslot_q : tfree;
		touch_wd.key   = id_q;
		touch_wd.found = near_res.found;
		touch_wd.hand  = near_res.hand;
		if (done_go) begin
			case (op_q)
				nht_pkg::OP_HAND: hand_we  = hmatch_q || hfree_any;
				nht_pkg::OP_DOWN: touch_we = tmatch_q || tfree_any;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (op_q == nht_pkg::OP_DOWN) begin
			res_found = near_res.found;
			res_hand  = near_res.hand;
		end else begin
			res_found = tmatch_q && tfound_q;
			res_hand  = (tmatch_q && tfound_q) ? thand_q : '0;
		end
	end

	// control

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			drain_q       <= 1'b0;
			issue_s1      <= 1'b0;
			hmatch_q      <= 1'b0;
			tmatch_q      <= 1'b0;
			hand_valid_q  <= '0;
			touch_valid_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			issue_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hmatch_q <= 1'b0;
						tmatch_q <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == last_q) begin
						drain_q <= 1'b0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (hand_live && (op_q == nht_pkg::OP_HAND) && (hand_rd.key == id_q) && !hmatch_q) begin
				hmatch_q <= 1'b1;
			end
			if (touch_live && !tmatch_q) begin
				tmatch_q <= 1'b1;
			end

			if (hand_we) begin
				hand_valid_q[hand_wa] <= 1'b1;
			end
			if (touch_we) begin
				touch_valid_q[touch_wa] <= 1'b1;
			end
			if (done_go && (op_q == nht_pkg::OP_UP) && tmatch_q) begin
				touch_valid_q[tslot_q] <= 1'b0;
			end

			if (done_go && (op_q != nht_pkg::OP_HAND)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= nht_pkg::op_t'(s_axis_tuser);
			id_q  <= s_axis_tdata[15:0];
			x_q   <= s_axis_tdata[31:16];
			y_q   <= s_axis_tdata[47:32];
			idx_q <= '0;
			case (nht_pkg::op_t'(s_axis_tuser))
				nht_pkg::OP_HAND: last_q <= nht_pkg::SCAN_IW'(nht_pkg::HAND_SLOTS - 1);
				nht_pkg::OP_DOWN: last_q <= nht_pkg::SCAN_IW'(nht_pkg::SCAN_N - 1);
				default:          last_q <= nht_pkg::SCAN_IW'(nht_pkg::TOUCH_SLOTS - 1);
			endcase
		end else if ((state_q == ST_SCAN) && (idx_q != last_q)) begin
			idx_q <= idx_q + nht_pkg::SCAN_IW'(1);
		end
		idx_s1 <= idx_q;

		if (hand_live && (hand_rd.key == id_q) && !hmatch_q) begin
			hslot_q <= hidx;
		end
		if (touch_live && !tmatch_q) begin
			tslot_q  <= tidx;
			tfound_q <= touch_rd.found;
			thand_q  <= touch_rd.hand;
		end

		if (done_go && (op_q != nht_pkg::OP_HAND)) begin
			out_id_q    <= id_q;
			out_kind_q  <= op_q;
			out_found_q <= res_found;
			out_hand_q  <= res_hand;
			out_x_q     <= x_q;
			out_y_q     <= y_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_y_q, out_x_q, out_hand_q, out_id_q};
	assign m_axis_tuser  = {out_found_q, out_kind_q};

	// hands are never removed, touches change one slot per beat at most
	`NHT_ASSERT_NXT(a_accept_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`NHT_ASSERT_NXT(a_hand_grow, clk, arst_n, 1'b1, $countones(hand_valid_q) >= $countones($past(hand_valid_q)))
	`NHT_ASSERT_NXT(a_touch_step, clk, arst_n, 1'b1, $countones(touch_valid_q ^ $past(touch_valid_q)) <= 1)
	`NHT_ASSERT_IMP(a_out_source, clk, arst_n, $rose(m_axis_tvalid), $past(state_q) == ST_DONE)

endmodule

### bench/nearest_hand_touch_tagger_test.sv
`timescale 1ns / 1ps

// drives hand updates and touch events into the tagger, keeps its own copy of the
// hand and touch tables to work out each tag, and checks every tag beat in order

module nearest_hand_touch_tagger_test;
	import nht_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 60;

	typedef struct {
		logic [15:0]        touch_id;
		op_t                kind;
		logic               found;
		logic [15:0]        hand;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} tag_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	// own copy of the tables
	bit                 hand_live [HAND_SLOTS];
	logic [15:0]        hand_tag  [HAND_SLOTS];
	logic signed [15:0] hand_px   [HAND_SLOTS];
	logic signed [15:0] hand_py   [HAND_SLOTS];
	bit                 pair_live [TOUCH_SLOTS];
	logic [15:0]        pair_touch[TOUCH_SLOTS];
	bit                 pair_found[TOUCH_SLOTS];
	logic [15:0]        pair_hand [TOUCH_SLOTS];

	tag_t        pending_tags[$];
	logic [15:0] touch_pool[24];
	logic [15:0] hand_pool[8];

	int errors = 0;
	int cycle_count = 0;
	int items_in = 0;
	int tags_seen = 0;
	int hands_dropped = 0;
	int pairs_not_kept = 0;
	int unknown_lookups = 0;
	int ties_seen = 0;
	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	int rx_hold = 0;

	nearest_hand_touch_tagger dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // item_id, pos_x, pos_y
		.s_axis_tuser  (s_axis_tuser),   // opcode
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // touch_id, hand_id, out_x, out_y
		.m_axis_tuser  (m_axis_tuser)    // touch_kind, hand_found
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tags outstanding", cycle_count,
				pending_tags.size());
			$display("status: fail");
			$finish;
		end
	end

	// updates the table copy for one accepted beat and queues the tag it causes
	task automatic tag_touch(input op_t op, input logic [15:0] id,
			input logic signed [15:0] x, input logic signed [15:0] y);
		int slot;
		longint dx;
		longint dy;
		longint dsq;
		longint best;
		tag_t t;
		slot = -1;
		best = 0;
		t.touch_id = id;
		t.kind = op;
		t.found = 1'b0;
		t.hand = '0;
		t.x = x;
		t.y = y;
		if (op == OP_HAND) begin
			for (int i = 0; i < HAND_SLOTS; i++)
				if (slot < 0 && hand_live[i] && hand_tag[i] == id)
					slot = i;
			for (int i = 0; i < HAND_SLOTS; i++)
				if (slot < 0 && !hand_live[i])
					slot = i;
			if (slot < 0) begin
				hands_dropped++;
			end else begin
				hand_live[slot] = 1'b1;
				hand_tag[slot] = id;
				hand_px[slot] = x;
				hand_py[slot] = y;
			end
			return;
		end
		for (int i = 0; i < TOUCH_SLOTS; i++)
			if (slot < 0 && pair_live[i] && pair_touch[i] == id)
				slot = i;
		if (op == OP_DOWN) begin
			for (int i = 0; i < HAND_SLOTS; i++) begin
				if (hand_live[i]) begin
					dx = longint'(x) - longint'(hand_px[i]);
					dy = longint'(y) - longint'(hand_py[i]);
					dsq = dx * dx + dy * dy;
					if (t.found && dsq == best)
						ties_seen++;
					if (!t.found || dsq < best || (dsq == best && hand_tag[i] < t.hand)) begin
						t.found = 1'b1;
						best = dsq;
						t.hand = hand_tag[i];
					end
				end
			end
			for (int i = 0; i < TOUCH_SLOTS; i++)
				if (slot < 0 && !pair_live[i])
					slot = i;
			if (slot < 0) begin
				pairs_not_kept++;
			end else begin
				pair_live[slot] = 1'b1;
				pair_touch[slot] = id;
				pair_found[slot] = t.found;
				pair_hand[slot] = t.hand;
			end
		end else if (slot < 0) begin
			unknown_lookups++;
		end else begin
			t.found = pair_found[slot];
			t.hand = pair_found[slot] ? pair_hand[slot] : 16'd0;
			if (op == OP_UP)
				pair_live[slot] = 1'b0;
		end
		pending_tags.push_back(t);
	endtask

	task automatic send_item(input op_t op, input logic [15:0] id,
			input logic signed [15:0] x, input logic signed [15:0] y);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x, id};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_in++;
		tag_touch(op, id, x, y);
	endtask

	task automatic report_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			errors++;
		end
	endtask

	// tag checker
	always @(posedge clk) begin
		tag_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tags_seen++;
			if (pending_tags.size() == 0) begin
				$error("tag beat with none expected: touch_id %0d", m_axis_tdata[15:0]);
				errors++;
			end else begin
				want = pending_tags.pop_front();
				report_field("touch_id", want.touch_id, m_axis_tdata[15:0]);
				report_field("touch_kind", want.kind, m_axis_tuser[1:0]);
				report_field("hand_found", want.found, m_axis_tuser[2]);
				report_field("hand_id", want.hand, m_axis_tdata[31:16]);
				report_field("out_x", want.x, $signed(m_axis_tdata[47:32]));
				report_field("out_y", want.y, $signed(m_axis_tdata[63:48]));
			end
		end
	end

	// receiver; a long hold-off is counted here
	initial begin : sink
		int n;
		forever begin
			@(posedge clk);
			n = 0;
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 19);
			end
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic signed [15:0] pick_coord(input bit near);
		if (near)
			return 16'($signed($urandom_range(0, 6)) - 3);
		return 16'($urandom);
	endfunction

	task automatic test_no_hands();
		send_item(OP_DOWN, 16'd0, 16'sd0, 16'sd0);
		send_item(OP_MOVE, 16'd0, 16'sd1, -16'sd1);
		send_item(OP_UP, 16'd0, 16'sd2, 16'sd2);
		send_item(OP_MOVE, 16'hffff, 16'sd5, 16'sd5);
		send_item(OP_UP, 16'd1234, -16'sd5, 16'sd5);
	endtask

	task automatic test_extreme_positions();
		send_item(OP_HAND, 16'hffff, 16'sh8000, 16'sh8000);
		// widest distance the tables can hold
		send_item(OP_DOWN, 16'd4, 16'sd32767, 16'sd32767);
		send_item(OP_HAND, 16'd0, 16'sd32767, 16'sd32767);
		// equal distance to both corners, the lower hand id wins though it sits later
		send_item(OP_DOWN, 16'd1, 16'sd32767, 16'sh8000);
		send_item(OP_DOWN, 16'd2, 16'sh8000, 16'sd32767);
	endtask

	task automatic test_repairing();
		send_item(OP_HAND, 16'hffff, 16'sd100, 16'sd100);
		send_item(OP_MOVE, 16'd4, 16'sd0, 16'sd0);
		send_item(OP_DOWN, 16'd4, 16'sd32767, 16'sd32767);
		send_item(OP_MOVE, 16'd4, 16'sd32767, 16'sd32766);
		send_item(OP_UP, 16'd4, 16'sd32767, 16'sd32766);
		send_item(OP_MOVE, 16'd4, 16'sd1, 16'sd1);
	endtask

	task automatic test_hand_table_full();
		for (int i = 0; i < 6; i++)
			send_item(OP_HAND, 16'(10 + i), 16'(1000 * (i + 1)), -16'sd2000);
		// no room left, so this one is dropped although it would be nearest
		send_item(OP_HAND, 16'd16, 16'sd7, 16'sd7);
		send_item(OP_DOWN, 16'd5, 16'sd7, 16'sd7);
	endtask

	task automatic test_touch_table_full();
		logic [15:0] base;
		base = 16'($urandom_range(100, 60000));
		for (int i = 0; i < TOUCH_SLOTS + 4; i++)
			send_item(OP_DOWN, base + 16'(i), pick_coord(1'b0), pick_coord(1'b0));
		for (int i = 0; i < TOUCH_SLOTS + 4; i++)
			send_item(OP_MOVE, base + 16'(i), pick_coord(1'b0), pick_coord(1'b0));
		for (int i = 0; i < TOUCH_SLOTS + 4; i++)
			send_item(OP_UP, base + 16'(i), pick_coord(1'b0), pick_coord(1'b0));
	endtask

	task automatic test_backpressure();
		rx_hold = 300;
		for (int i = 0; i < 30; i++)
			send_item(op_t'($urandom_range(1, 3)), touch_pool[$urandom_range(0, 23)],
				pick_coord(1'b0), pick_coord(1'b0));
	endtask

	// mostly touch lifecycles on a small id pool with hands moving about; some noise
	task automatic test_random_gestures(input int count);
		int roll;
		bit near;
		op_t op;
		logic [15:0] id;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			near = ($urandom_range(0, 3) == 0);
			if (roll < 22) begin
				op = OP_HAND;
				id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : hand_pool[$urandom_range(0, 7)];
			end else if (roll < 94) begin
				op = (roll < 50) ? OP_DOWN : (roll < 76) ? OP_MOVE : OP_UP;
				id = touch_pool[$urandom_range(0, 23)];
			end else begin
				op = op_t'($urandom_range(1, 3));
				id = 16'($urandom);
			end
			send_item(op, id, pick_coord(near), pick_coord(near));
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < 24; i++)
			touch_pool[i] = 16'($urandom);
		touch_pool[0] = 16'd0;
		touch_pool[1] = 16'hffff;
		hand_pool = '{16'hffff, 16'd0, 16'd10, 16'd11, 16'd12, 16'd13, 16'd14, 16'd15};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_hands();
		test_extreme_positions();
		test_repairing();
		test_hand_table_full();
		test_touch_table_full();
		test_backpressure();
		test_random_gestures(550);
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_random_gestures(150);
		drain();

		$display("sent %0d items and checked %0d tags in %0d cycles", items_in, tags_seen,
			cycle_count);
		$display("dropped hands %0d, pairings not kept %0d, unknown touches %0d, ties %0d",
			hands_dropped, pairs_not_kept, unknown_lookups, ties_seen);
		if (pending_tags.size() != 0) begin
			$error("%0d tags never arrived", pending_tags.size());
			errors++;
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
